FILE: src/opd_pkg.sv
package opd_pkg;

   typedef enum logic [2:0] {
      PH_TAG     = 3'd0,
      PH_NEWLEN  = 3'd1,
      PH_NEW2ND  = 3'd2,
      PH_LENMORE = 3'd3,
      PH_BODY    = 3'd4,
      PH_SEGLEN  = 3'd5
   } phase_type;

   localparam logic [2:0] ROLE_TAG     = 3'd0;
   localparam logic [2:0] ROLE_LEN     = 3'd1;
   localparam logic [2:0] ROLE_BODY    = 3'd2;
   localparam logic [2:0] ROLE_SEGLEN  = 3'd3;
   localparam logic [2:0] ROLE_DISCARD = 3'd4;

   localparam logic [1:0] KIND_FIXED   = 2'd0;
   localparam logic [1:0] KIND_PARTIAL = 2'd1;
   localparam logic [1:0] KIND_SEG     = 2'd2;

   localparam logic REG_CHECK_TYPE    = 1'b0;
   localparam logic REG_EXPECTED_TYPE = 1'b1;

   localparam logic       CHECK_TYPE_RST    = 1'b1;
   localparam logic [5:0] EXPECTED_TYPE_RST = 6'd2;

   typedef struct packed {
      logic       check_type;
      logic [5:0] expected_type;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [2:0]  byte_role;
      logic        header_done;
      logic [5:0]  packet_type;
      logic [31:0] packet_length;
      logic [1:0]  partial_kind;
      logic [2:0]  header_length;
      logic        bad_header;
      logic        type_mismatch;
      logic        packet_end;
   } result_type;

endpackage

FILE: src/opd_parser.sv
module opd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          in_byte,
   input  opd_pkg::cfg_type    cfg,
   output opd_pkg::result_type res
);

   opd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  tag_ff, tag_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  lbl_ff, lbl_in;
   logic [31:0] body_ff, body_in;
   logic [2:0]  hc_ff, hc_in;
   logic        seg_ff, seg_in;

   logic        hd;
   logic [31:0] hd_len;
   logic [1:0]  hd_kind;
   logic [2:0]  hd_hlen;
   logic [5:0]  pkt_type;
   logic [31:0] acc_shift;
   logic [2:0]  lbl_dec;
   logic [31:0] body_dec;

   assign acc_shift = {acc_ff[23:0], in_byte};
   assign lbl_dec   = (lbl_ff != 3'd0) ? lbl_ff - 3'd1 : 3'd0;
   assign body_dec  = (body_ff != 32'd0) ? body_ff - 32'd1 : 32'd0;

   always_comb begin
      phase_in = phase_ff;
      tag_in   = tag_ff;
      acc_in   = acc_ff;
      lbl_in   = lbl_ff;
      body_in  = body_ff;
      hc_in    = hc_ff;
      seg_in   = seg_ff;
      res      = '0;
      res.out_byte = in_byte;
      hd       = 1'b0;
      hd_len   = '0;
      hd_kind  = opd_pkg::KIND_FIXED;
      hd_hlen  = '0;

      unique case (phase_ff)
         opd_pkg::PH_NEWLEN: begin
            res.byte_role = opd_pkg::ROLE_LEN;
            hc_in = 3'd2;
            if (in_byte < 8'd192) begin
               hd      = 1'b1;
               hd_len  = {24'd0, in_byte};
               hd_hlen = 3'd2;
            end else if (in_byte < 8'd224) begin
               acc_in   = {24'd0, in_byte - 8'd192};
               phase_in = opd_pkg::PH_NEW2ND;
            end else if (in_byte == 8'd255) begin
               acc_in   = '0;
               lbl_in   = 3'd4;
               phase_in = opd_pkg::PH_LENMORE;
            end else begin
               // partial length: report it and drop the continuation
               hd      = 1'b1;
               hd_len  = {24'd0, in_byte};
               hd_kind = opd_pkg::KIND_PARTIAL;
               hd_hlen = 3'd2;
            end
         end
         opd_pkg::PH_NEW2ND: begin
            res.byte_role = opd_pkg::ROLE_LEN;
            hc_in   = 3'd3;
            hd      = 1'b1;
            hd_len  = {acc_ff[23:0], in_byte} + 32'd192;
            hd_hlen = 3'd3;
         end
         opd_pkg::PH_LENMORE: begin
            res.byte_role = opd_pkg::ROLE_LEN;
            hc_in  = hc_ff + 3'd1;
            acc_in = acc_shift;
            lbl_in = lbl_dec;
            if (lbl_dec == 3'd0) begin
               hd      = 1'b1;
               hd_len  = acc_shift;
               hd_hlen = hc_ff + 3'd1;
            end
         end
         opd_pkg::PH_BODY: begin
            res.byte_role = opd_pkg::ROLE_BODY;
            body_in = body_dec;
            if (body_dec == 32'd0) begin
               if (seg_ff) begin
                  acc_in   = '0;
                  lbl_in   = 3'd2;
                  phase_in = opd_pkg::PH_SEGLEN;
               end else begin
                  res.packet_end = 1'b1;
                  phase_in       = opd_pkg::PH_TAG;
               end
            end
         end
         opd_pkg::PH_SEGLEN: begin
            res.byte_role = opd_pkg::ROLE_SEGLEN;
            acc_in = acc_shift;
            lbl_in = lbl_dec;
            if (lbl_dec == 3'd0) begin
               if (acc_shift[15:0] == 16'd0) begin
                  res.packet_end = 1'b1;
                  seg_in         = 1'b0;
                  phase_in       = opd_pkg::PH_TAG;
               end else begin
                  body_in  = {16'd0, acc_shift[15:0]};
                  phase_in = opd_pkg::PH_BODY;
               end
            end
         end
         default: begin
            if (!in_byte[7]) begin
               res.byte_role  = opd_pkg::ROLE_DISCARD;
               res.bad_header = 1'b1;
               phase_in       = opd_pkg::PH_TAG;
            end else begin
               res.byte_role = opd_pkg::ROLE_TAG;
               tag_in = in_byte;
               hc_in  = 3'd1;
               acc_in = '0;
               seg_in = 1'b0;
               if (in_byte[6]) begin
                  phase_in = opd_pkg::PH_NEWLEN;
               end else if (in_byte[1:0] == 2'b11) begin
                  seg_in  = 1'b1;
                  hd      = 1'b1;
                  hd_len  = '0;
                  hd_kind = opd_pkg::KIND_SEG;
                  hd_hlen = 3'd1;
               end else begin
                  lbl_in   = 3'd1 << in_byte[1:0];
                  phase_in = opd_pkg::PH_LENMORE;
               end
            end
         end
      endcase

      // new format keeps 6 type bits, old format 4
      pkt_type = tag_in[6] ? tag_in[5:0] : {2'b00, tag_in[5:2]};

      if (hd) begin
         res.header_done   = 1'b1;
         res.packet_type   = pkt_type;
         res.packet_length = hd_len;
         res.partial_kind  = hd_kind;
         res.header_length = hd_hlen;
         res.type_mismatch = cfg.check_type && (pkt_type != cfg.expected_type);
         if (hd_kind == opd_pkg::KIND_SEG) begin
            lbl_in   = 3'd2;
            acc_in   = '0;
            phase_in = opd_pkg::PH_SEGLEN;
         end else if (hd_kind == opd_pkg::KIND_PARTIAL || hd_len == 32'd0) begin
            res.packet_end = 1'b1;
            phase_in       = opd_pkg::PH_TAG;
         end else begin
            body_in  = hd_len;
            phase_in = opd_pkg::PH_BODY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= opd_pkg::PH_TAG;
         tag_ff   <= '0;
         acc_ff   <= '0;
         lbl_ff   <= '0;
         body_ff  <= '0;
         hc_ff    <= '0;
         seg_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         tag_ff   <= tag_in;
         acc_ff   <= acc_in;
         lbl_ff   <= lbl_in;
         body_ff  <= body_in;
         hc_ff    <= hc_in;
         seg_ff   <= seg_in;
      end
   end

`ifndef SYNTHESIS
   a_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == opd_pkg::PH_BODY |-> body_ff != 32'd0)
      else $error("body phase with zero byte count");

   a_seglen_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == opd_pkg::PH_SEGLEN |-> (lbl_ff == 3'd1 || lbl_ff == 3'd2))
      else $error("segment length count out of range");

   a_lenmore_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == opd_pkg::PH_LENMORE |-> lbl_ff != 3'd0)
      else $error("length phase with no length bytes left");
`endif

endmodule

FILE: src/openpgp_packet_deframer_top.sv
// Packet stream deframer: one stream byte per word on the req_ channel,
// one tagged word per input byte on the rsp_ channel, in order.
// Each result carries the byte, its role (tag, length, body, segment
// length, discarded) and, on the last header byte, the packet type, body
// length, length kind and header size. packet_end marks the final byte.
// A word is taken when valid is high and stall is low on that channel.
// An accepted byte passes one input register, then the parse logic into
// the result register. Throughput is one byte per cycle while rsp_stall
// is low; the only loop is the parser state, updated once per byte.
// When the receiver stalls, the result holds; at most one more byte is
// taken, and req_stall is high while the input register holds a byte.
// Reset (synchronous, active high) empties both stages, returns the
// parser to waiting for a tag byte and loads check_type = 1 and
// expected_type = 2. Registers sit on the APB port: check_type at 0x0,
// expected_type at 0x4; write them only while the block is idle.
module openpgp_packet_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_byte_role,
   output logic        rsp_header_done,
   output logic [5:0]  rsp_packet_type,
   output logic [31:0] rsp_packet_length,
   output logic [1:0]  rsp_partial_kind,
   output logic [2:0]  rsp_header_length,
   output logic        rsp_bad_header,
   output logic        rsp_type_mismatch,
   output logic        rsp_packet_end,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                in_vld_ff, in_vld_in;
   logic [7:0]          in_byte_ff;
   logic                rsp_vld_ff, rsp_vld_in;
   opd_pkg::result_type rsp_ff, res;
   opd_pkg::cfg_type    cfg_ff;
   logic                advance;
   logic                accept;
   logic                csr_wr;

   assign advance   = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance) begin
         rsp_ff <= res;
      end
   end

   opd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .res     (res)
   );

   // register file
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.check_type    <= opd_pkg::CHECK_TYPE_RST;
         cfg_ff.expected_type <= opd_pkg::EXPECTED_TYPE_RST;
      end else if (csr_wr) begin
         unique case (paddr[2])
            opd_pkg::REG_CHECK_TYPE:    cfg_ff.check_type    <= pwdata[0];
            opd_pkg::REG_EXPECTED_TYPE: cfg_ff.expected_type <= pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         opd_pkg::REG_CHECK_TYPE:    prdata = {31'd0, cfg_ff.check_type};
         opd_pkg::REG_EXPECTED_TYPE: prdata = {26'd0, cfg_ff.expected_type};
         default:                    prdata = '0;
      endcase
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_out_byte      = rsp_ff.out_byte;
   assign rsp_byte_role     = rsp_ff.byte_role;
   assign rsp_header_done   = rsp_ff.header_done;
   assign rsp_packet_type   = rsp_ff.packet_type;
   assign rsp_packet_length = rsp_ff.packet_length;
   assign rsp_partial_kind  = rsp_ff.partial_kind;
   assign rsp_header_length = rsp_ff.header_length;
   assign rsp_bad_header    = rsp_ff.bad_header;
   assign rsp_type_mismatch = rsp_ff.type_mismatch;
   assign rsp_packet_end    = rsp_ff.packet_end;

`ifndef SYNTHESIS
   a_hdr_role: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.header_done |->
         (rsp_ff.byte_role == opd_pkg::ROLE_TAG || rsp_ff.byte_role == opd_pkg::ROLE_LEN))
      else $error("header end on a non-header word");

   a_bad_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.bad_header |->
         (rsp_ff.byte_role == opd_pkg::ROLE_DISCARD && !rsp_ff.header_done
          && !rsp_ff.packet_end))
      else $error("bad header word with packet markers");

   a_mismatch_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.type_mismatch |-> rsp_ff.header_done)
      else $error("type mismatch outside header end");
`endif

endmodule
